// ===== hw/rtl/tfj_pkg.sv =====
// shared types and constants for the text justification block
package tfj_pkg;

    localparam int MAX_WIDTH = 32;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [5:0] WIDTH_RESET = 6'd16;

    typedef struct packed {
        logic [7:0] char_in;
        logic       word_end;
        logic       text_end;
    } in_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       line_end;
        logic       text_done;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT,
        ST_COPY
    } state_t;

    typedef enum logic [1:0] {
        PH_WORD,
        PH_GAP,
        PH_PAD
    } phase_t;

    typedef struct packed {
        logic       start;
        logic [5:0] dividend;
        logic [4:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic       busy;
        logic       done;
        logic [5:0] quot;
        logic [4:0] rem;
    } div_rsp_t;

endpackage

// ===== hw/rtl/text_full_justify.sv =====
// greedy full text justification, one word character in, one line character out
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    tfj_pkg::in_t  (char_in, word_end, text_end)
//  m_        out        m_valid / m_ready    tfj_pkg::out_t (char_out, line_end, text_done)
//  cfg_      in         cfg_valid/cfg_ready  line_width, 6 bits
//
//  a character that does not end a word is only added to the arriving word
//  a word end is accepted; if the word does not fit, the gaps of the held line are divided
//  (no division when the line is not spread) and the line is emitted, one character at a
//  time through the single output register; then the word and its length are moved into
//  the line buffer, after which a word that ends the text emits the final line
//  s_ready is low while a word is moved, the gaps are divided or a line is emitted
//  synchronous active-low reset clears control state; buffers hold no reset value
//  a stalled m_ready freezes the emission cursor in place
module text_full_justify (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tfj_pkg::in_t       s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tfj_pkg::out_t      m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [5:0]         cfg_data
);

    localparam int DEPTH = tfj_pkg::MAX_WIDTH;

    // line width register and its clamped value
    logic [5:0] lw_reg;
    logic [5:0] eff_w;

    tfj_pkg::state_t state_reg, state_next;
    tfj_pkg::phase_t phase_reg, phase_next;

    logic [5:0] plen_reg, plen_next;      // arriving word length
    logic [5:0] words_reg, words_next;    // held words
    logic [5:0] letters_reg, letters_next;
    logic       last_reg, last_next;      // text end seen with this word
    logic       fin_reg, fin_next;        // current emission is the final line
    logic [5:0] base_reg, base_next;
    logic [4:0] rem_reg, rem_next;
    logic [5:0] ck_reg, ck_next;          // copy index
    // emission cursor
    logic [5:0] oidx_reg, oidx_next;
    logic [4:0] wi_reg, wi_next;
    logic [5:0] wj_reg, wj_next;
    logic [5:0] pos_reg, pos_next;
    logic [5:0] gr_reg, gr_next;

    logic          m_valid_reg, m_valid_next;
    tfj_pkg::out_t m_data_reg, m_data_next;

    // buffers
    logic [7:0] pend_mem [DEPTH];
    logic [7:0] text_mem [DEPTH];
    logic [5:0] wlen_mem [DEPTH];

    logic       pend_we, text_we, wlen_we;
    logic [4:0] text_waddr, wlen_waddr;
    logic [7:0] text_wdata;

    tfj_pkg::div_req_t div_req;
    tfj_pkg::div_rsp_t div_rsp;

    logic [5:0] plen_new;
    logic [6:0] need;
    logic [5:0] gaps;
    logic [6:0] single_len;
    logic [5:0] cur_wlen;
    logic       line_last;

    tfj_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign eff_w = (lw_reg == 6'd0) ? 6'd1 :
                   (lw_reg > 6'(DEPTH)) ? 6'(DEPTH) : lw_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_reg      <= tfj_pkg::WIDTH_RESET;
            state_reg   <= tfj_pkg::ST_IDLE;
            plen_reg    <= 6'd0;
            words_reg   <= 6'd0;
            letters_reg <= 6'd0;
            last_reg    <= 1'b0;
            fin_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                lw_reg <= cfg_data;
            end
            state_reg   <= state_next;
            plen_reg    <= plen_next;
            words_reg   <= words_next;
            letters_reg <= letters_next;
            last_reg    <= last_next;
            fin_reg     <= fin_next;
            m_valid_reg <= m_valid_next;
        end
        phase_reg  <= phase_next;
        base_reg   <= base_next;
        rem_reg    <= rem_next;
        ck_reg     <= ck_next;
        oidx_reg   <= oidx_next;
        wi_reg     <= wi_next;
        wj_reg     <= wj_next;
        pos_reg    <= pos_next;
        gr_reg     <= gr_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (pend_we) begin
            pend_mem[plen_reg[4:0]] <= s_data.char_in;
        end
        if (text_we) begin
            text_mem[text_waddr] <= text_wdata;
        end
        if (wlen_we) begin
            wlen_mem[wlen_waddr] <= plen_reg;
        end
    end

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        plen_next    = plen_reg;
        words_next   = words_reg;
        letters_next = letters_reg;
        last_next    = last_reg;
        fin_next     = fin_reg;
        base_next    = base_reg;
        rem_next     = rem_reg;
        ck_next      = ck_reg;
        oidx_next    = oidx_reg;
        wi_next      = wi_reg;
        wj_next      = wj_reg;
        pos_next     = pos_reg;
        gr_next      = gr_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        s_ready      = 1'b0;
        pend_we      = 1'b0;
        text_we      = 1'b0;
        text_waddr   = letters_reg[4:0];
        text_wdata   = pend_mem[ck_reg[4:0]];
        wlen_we      = 1'b0;
        wlen_waddr   = words_reg[4:0];
        div_req      = '0;

        plen_new   = plen_reg + ((plen_reg < eff_w) ? 6'd1 : 6'd0);
        need       = {1'b0, words_reg} + {1'b0, letters_reg} + {1'b0, plen_new};
        gaps       = words_reg - 6'd1;
        single_len = {1'b0, letters_reg} + {1'b0, gaps};
        cur_wlen   = wlen_mem[wi_reg];
        line_last  = (oidx_reg == eff_w - 6'd1);

        div_req.dividend = eff_w - letters_reg;
        div_req.divisor  = gaps[4:0];

        case (state_reg)
            tfj_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    // keep the character unless the word already fills a line
                    if (plen_reg < eff_w) begin
                        pend_we   = 1'b1;
                        plen_next = plen_new;
                    end
                    if (s_data.word_end) begin
                        last_next = s_data.text_end;
                        ck_next   = 6'd0;
                        if (words_reg != 6'd0 && need > {1'b0, eff_w}) begin
                            state_next = tfj_pkg::ST_DIV_START;
                        end else begin
                            state_next = tfj_pkg::ST_COPY;
                        end
                    end
                end
            end
            tfj_pkg::ST_DIV_START: begin
                oidx_next  = 6'd0;
                wi_next    = 5'd0;
                wj_next    = 6'd0;
                pos_next   = 6'd0;
                phase_next = tfj_pkg::PH_WORD;
                // spread only when the words fit with single gaps
                if (words_reg > 6'd1 && {1'b0, eff_w} >= single_len) begin
                    div_req.start = 1'b1;
                    state_next    = tfj_pkg::ST_DIV_WAIT;
                end else begin
                    base_next  = 6'd1;
                    rem_next   = 5'd0;
                    state_next = tfj_pkg::ST_EMIT;
                end
            end
            tfj_pkg::ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    base_next  = div_rsp.quot;
                    rem_next   = div_rsp.rem;
                    state_next = tfj_pkg::ST_EMIT;
                end
            end
            tfj_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.char_out   = (phase_reg == tfj_pkg::PH_WORD) ?
                                             text_mem[pos_reg[4:0]] : tfj_pkg::SPACE_CHAR;
                    m_data_next.line_end   = line_last;
                    m_data_next.text_done  = line_last & fin_reg;
                    oidx_next              = oidx_reg + 6'd1;
                    case (phase_reg)
                        tfj_pkg::PH_WORD: begin
                            pos_next = pos_reg + 6'd1;
                            wj_next  = wj_reg + 6'd1;
                            if (wj_reg + 6'd1 >= cur_wlen) begin
                                wj_next = 6'd0;
                                if ({1'b0, wi_reg} + 6'd1 < words_reg) begin
                                    phase_next = tfj_pkg::PH_GAP;
                                    gr_next    = base_reg + ((wi_reg < rem_reg) ? 6'd1 : 6'd0);
                                end else begin
                                    phase_next = tfj_pkg::PH_PAD;
                                end
                            end
                        end
                        tfj_pkg::PH_GAP: begin
                            if (gr_reg <= 6'd1) begin
                                phase_next = tfj_pkg::PH_WORD;
                                wi_next    = wi_reg + 5'd1;
                            end else begin
                                gr_next = gr_reg - 6'd1;
                            end
                        end
                        default: begin
                            phase_next = tfj_pkg::PH_PAD;
                        end
                    endcase
                    if (line_last) begin
                        words_next   = 6'd0;
                        letters_next = 6'd0;
                        if (fin_reg) begin
                            fin_next   = 1'b0;
                            last_next  = 1'b0;
                            state_next = tfj_pkg::ST_IDLE;
                        end else begin
                            ck_next    = 6'd0;
                            state_next = tfj_pkg::ST_COPY;
                        end
                    end
                end
            end
            tfj_pkg::ST_COPY: begin
                if (ck_reg < plen_reg) begin
                    // characters past the buffer end are dropped
                    if (letters_reg < 6'(DEPTH)) begin
                        text_we      = 1'b1;
                        letters_next = letters_reg + 6'd1;
                    end
                    ck_next = ck_reg + 6'd1;
                end else begin
                    if (words_reg < 6'(DEPTH)) begin
                        wlen_we    = 1'b1;
                        words_next = words_reg + 6'd1;
                    end
                    plen_next = 6'd0;
                    if (last_reg) begin
                        // final line: single gaps, padded on the right
                        fin_next   = 1'b1;
                        base_next  = 6'd1;
                        rem_next   = 5'd0;
                        oidx_next  = 6'd0;
                        wi_next    = 5'd0;
                        wj_next    = 6'd0;
                        pos_next   = 6'd0;
                        phase_next = tfj_pkg::PH_WORD;
                        state_next = tfj_pkg::ST_EMIT;
                    end else begin
                        state_next = tfj_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = tfj_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    ast_cursor_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tfj_pkg::ST_EMIT) |-> (oidx_reg < eff_w))
        else $error("emission cursor past line width");
    ast_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tfj_pkg::ST_EMIT && fin_reg && line_last && (!m_valid_reg || m_ready))
        |=> (words_reg == 6'd0 && letters_reg == 6'd0 && plen_reg == 6'd0))
        else $error("line state not cleared after final line");
    ast_word_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tfj_pkg::ST_IDLE) |-> (plen_reg <= 6'(DEPTH) && letters_reg <= 6'(DEPTH)))
        else $error("word or line length beyond buffer");
    ast_div_only_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == tfj_pkg::ST_DIV_WAIT))
        else $error("gap division finished outside wait state");

endmodule

// ===== hw/rtl/tfj_div.sv =====
// restoring divider, one quotient bit per cycle
module tfj_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  tfj_pkg::div_req_t   req,
    output tfj_pkg::div_rsp_t   rsp
);

    logic [5:0] q_reg, q_next;
    logic [5:0] r_reg, r_next;
    logic [4:0] d_reg, d_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [5:0] trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[4:0], q_reg[5]};
        if (req.start) begin
            q_next    = req.dividend;
            r_next    = 6'd0;
            d_next    = req.divisor;
            cnt_next  = 3'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift in next dividend bit, subtract when it fits
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[4:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[4:0], 1'b0};
            end
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd5) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem  = r_reg[4:0];

    ast_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> $past(busy_reg))
        else $error("divider done without a running division");
    ast_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider busy and done together");
    ast_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (r_reg < {1'b0, d_reg}))
        else $error("divider remainder not below divisor");

endmodule

// ===== bench/tb_text_full_justify.sv =====
// testbench for the text justification block: directed table, directed widths, then random words
module tb_text_full_justify;

    localparam int STALL_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    tfj_pkg::in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    tfj_pkg::out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [5:0] cfg_data = '0;

    text_full_justify i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state: held line, word lengths, arriving word
    logic [7:0] held_text [tfj_pkg::MAX_WIDTH];
    logic [5:0] held_lens [tfj_pkg::MAX_WIDTH];
    int unsigned held_words, held_letters, word_len;
    logic [7:0] word_buf [tfj_pkg::MAX_WIDTH];
    logic [5:0] width_reg;

    tfj_pkg::out_t line_chars_q[$];     // expected output characters, oldest first
    int errors = 0;
    int send_idle_pct = 0;     // sender gap probability
    int recv_stall_pct = 0;    // receiver stall probability
    int quiet_cycles = 0;

    task automatic report_mismatch(input string what, input tfj_pkg::out_t got,
                                   input tfj_pkg::out_t want);
        $display("mismatch %s: got %h/%b/%b want %h/%b/%b at %0t", what,
                 got.char_out, got.line_end, got.text_done,
                 want.char_out, want.line_end, want.text_done, $time);
        errors++;
    endtask

    function automatic int unsigned live_width();
        if (width_reg == 0) return 1;
        if (width_reg > tfj_pkg::MAX_WIDTH) return tfj_pkg::MAX_WIDTH;
        return width_reg;
    endfunction

    // lay out the held line and queue its characters, then clear the line
    function automatic void queue_line(input bit justify, input bit last);
        logic [7:0] buf_c [2*tfj_pkg::MAX_WIDTH+2];
        int unsigned len, pos, w, gaps, base, extra, g;
        tfj_pkg::out_t r;
        len = 0; pos = 0; w = live_width(); base = 1; extra = 0;
        gaps = (held_words > 1) ? held_words - 1 : 0;
        if (justify && gaps > 0 && w >= held_letters + gaps) begin
            base = (w - held_letters) / gaps;
            extra = (w - held_letters) % gaps;
        end
        for (int i = 0; i < held_words && i < tfj_pkg::MAX_WIDTH; i++) begin
            for (int j = 0; j < held_lens[i] && pos < tfj_pkg::MAX_WIDTH; j++) begin
                buf_c[len] = held_text[pos];
                len++; pos++;
            end
            if (i + 1 < held_words) begin
                g = base + ((i < extra) ? 1 : 0);
                for (int j = 0; j < g && len < 2*tfj_pkg::MAX_WIDTH+2; j++) begin
                    buf_c[len] = tfj_pkg::SPACE_CHAR;
                    len++;
                end
            end
        end
        for (int i = 0; i < w; i++) begin
            r.char_out = (i < len) ? buf_c[i] : tfj_pkg::SPACE_CHAR;
            r.line_end = (i + 1 == w);
            r.text_done = last && (i + 1 == w);
            line_chars_q = {line_chars_q, r};
        end
        held_words = 0;
        held_letters = 0;
    endfunction

    // one accepted character through the justifier
    function automatic void justify_char(input tfj_pkg::in_t it);
        int unsigned w;
        w = live_width();
        if (word_len < w) begin
            word_buf[word_len] = it.char_in;
            word_len++;
        end
        if (!it.word_end) return;
        if (held_words > 0 && held_words + held_letters + word_len > w)
            queue_line(1'b1, 1'b0);
        for (int i = 0; i < word_len && held_letters < tfj_pkg::MAX_WIDTH; i++) begin
            held_text[held_letters] = word_buf[i];
            held_letters++;
        end
        if (held_words < tfj_pkg::MAX_WIDTH) begin
            held_lens[held_words] = 6'(word_len);
            held_words++;
        end
        word_len = 0;
        if (it.text_end) queue_line(1'b0, 1'b1);
    endfunction

    // receiver: random stalls, checks each output transaction
    always @(posedge aclk) begin
        tfj_pkg::out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (line_chars_q.size() == 0) begin
                    report_mismatch("unexpected", m_data, '0);
                end else begin
                    want = line_chars_q.pop_front();
                    if (m_data !== want) report_mismatch("field", m_data, want);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no transaction at all
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout");
            $display("== FAIL ==");
            $finish;
        end
    end

    // valid drops only when the sender idles or drains, so back to back rows keep it high
    task automatic send_char(input tfj_pkg::in_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        justify_char(it);
    endtask

    // wait for every expected character, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        while (line_chars_q.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_width(input logic [5:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        width_reg = v;
    endtask

    // a word of random characters; the last one may end the text
    task automatic send_word(input int n, input bit last);
        tfj_pkg::in_t it;
        for (int i = 0; i < n; i++) begin
            it.char_in = 8'($urandom_range(255));
            it.word_end = (i == n - 1);
            it.text_end = (i == n - 1) ? last : 1'($urandom_range(1));
            send_char(it);
        end
    endtask

    // directed table: char, word_end, text_end
    localparam int NDIR = 12;
    tfj_pkg::in_t dir_tab [NDIR] = '{
        '{8'h00, 1'b1, 1'b1},   // one-char text after reset, padded to width 16
        '{8'hFF, 1'b0, 1'b1},   // text end without word end is ignored
        '{8'h41, 1'b1, 1'b0},
        '{8'h42, 1'b0, 1'b0},
        '{8'h43, 1'b1, 1'b0},
        '{8'h20, 1'b0, 1'b0},
        '{8'h7F, 1'b1, 1'b0},
        '{8'h80, 1'b1, 1'b1},
        '{8'h55, 1'b0, 1'b0},
        '{8'hAA, 1'b1, 1'b0},
        '{8'h01, 1'b1, 1'b0},
        '{8'hFE, 1'b1, 1'b1}
    };

    initial begin
        tfj_pkg::out_t want;
        tfj_pkg::out_t seen;
        held_words = 0; held_letters = 0; word_len = 0; width_reg = tfj_pkg::WIDTH_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // the first row's line is readable at a glance: char 0 then 15 spaces
        send_char(dir_tab[0]);
        for (int i = 0; i < 16; i++) begin
            want.char_out = (i == 0) ? 8'h00 : tfj_pkg::SPACE_CHAR;
            want.line_end = (i == 15);
            want.text_done = (i == 15);
            seen = (line_chars_q.size() > i) ? line_chars_q[i] : '0;
            if (line_chars_q.size() <= i || seen !== want)
                report_mismatch("directed", seen, want);
        end
        for (int k = 1; k < NDIR; k++) send_char(dir_tab[k]);

        // overlong word at width 1 and 0, width shrunk with a held line
        write_width(6'd1);
        send_word(5, 1'b0);
        send_word(3, 1'b1);
        write_width(6'd0);
        send_word(2, 1'b1);
        write_width(6'd32);
        send_word(10, 1'b0);
        send_word(12, 1'b0);
        write_width(6'd3);
        send_word(1, 1'b0);
        send_word(1, 1'b1);
        write_width(6'd63);
        send_word(40, 1'b0);
        send_word(2, 1'b1);

        // random phases: idle mix and width change per phase
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            write_width((ph == 3) ? 6'd32 : 6'($urandom_range(63)));
            for (int k = 0; k < 2; k++) begin
                send_word($urandom_range(1, 8), ($urandom_range(9) == 0));
            end
            send_word($urandom_range(1, 4), 1'b1);
            if (ph == 1) drain();  // sender holds until all lines are out
        end

        drain();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
